FILE: sv/assert_macros.svh
// Assertion macros shared by the compressor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: sv/dwc_pkg.sv
// Types and constants of the deadband waveform compressor.
package dwc_pkg;

  localparam int CH_W       = 8;
  localparam int TIME_W     = 56;
  localparam int VAL_W      = 48;
  localparam int STEP_W     = 47;
  localparam int CFG_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd2;

  // Unit kind codes.
  localparam logic [1:0] UNIT_CURRENT = 2'd0;
  localparam logic [1:0] UNIT_VOLTAGE = 2'd1;
  localparam logic [1:0] UNIT_NONE    = 2'd2;
  localparam logic [1:0] UNIT_OTHER   = 2'd3;

  // Register reset values.
  localparam logic [STEP_W-1:0] VOLT_STEP_RST    = 47'd10000000000;
  localparam logic [STEP_W-1:0] CURRENT_STEP_RST = 47'd10000000;
  localparam logic [TIME_W-1:0] TIME_STEP_RST    = 56'd1000;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic [STEP_W-1:0] volt_step;
    logic [STEP_W-1:0] current_step;
    logic [TIME_W-1:0] time_step;
  } cfg_t;

  // One channel's stored state: flags, last kept point and held point.
  typedef struct packed {
    logic                     has_kept;
    logic                     held_valid;
    logic [TIME_W-1:0]        lk_time;
    logic signed [VAL_W-1:0]  lk_value;
    logic [TIME_W-1:0]        held_time;
    logic signed [VAL_W-1:0]  held_value;
  } chan_word_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic [TIME_W-1:0]       time_fs;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } point_t;

  // Up to two result beats written into the queue in one cycle.
  typedef struct packed {
    logic   push0;
    logic   push1;
    point_t pt0;
    point_t pt1;
  } push_t;

endpackage

FILE: sv/dwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/dwc_out_fifo.sv
// Result queue: takes up to two points a cycle, delivers one beat a cycle while out_ready is high.
`include "assert_macros.svh"

module dwc_out_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dwc_pkg::push_t            push,
  output logic [dwc_pkg::CNT_W-1:0] free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dwc_pkg::point_t           out_pt
);
  import dwc_pkg::*;

  point_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_pt    = mem[rp_r];
  assign pop       = out_valid && out_ready;
  assign free      = CNT_W'(FIFO_DEPTH) - count_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + PTR_W'(push.push0) + PTR_W'(push.push1);
      rp_r    <= rp_r + PTR_W'(pop);
      count_r <= count_r + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end
  end

  // Entry storage; the second point lands behind the first.
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wp_r] <= push.pt0;
    end
    if (push.push1) begin
      mem[wp_r + PTR_W'(1)] <= push.pt1;
    end
  end

  `ASSERT_CLK(a_pair_in_order, push.push1 |-> push.push0)
  `ASSERT_CLK(a_no_overflow, push.push0 |-> (count_r + CNT_W'(push.push1)) < CNT_W'(FIFO_DEPTH))
  `ASSERT_CLK(a_count_tracks, $past(rst_n) |-> count_r == CNT_W'($past(count_r) + $past(CNT_W'(push.push0)) + $past(CNT_W'(push.push1)) - $past(CNT_W'(pop))))

endmodule

FILE: sv/dwc_chan_pipe.sv
// Channel state pipeline: state read, difference compute, decide and write back.
`include "assert_macros.svh"

module dwc_chan_pipe #(
  parameter int CHANNELS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dwc_pkg::CH_W-1:0]         in_ch,
  input  logic [dwc_pkg::TIME_W-1:0]       in_time,
  input  logic signed [dwc_pkg::VAL_W-1:0] in_value,
  input  logic [1:0]                       in_unit,
  input  dwc_pkg::cfg_t                    cfg,
  input  logic [dwc_pkg::CNT_W-1:0]        fifo_free,
  output dwc_pkg::push_t                   push
);
  import dwc_pkg::*;

  localparam int DEPTH = (CHANNELS < 256) ? CHANNELS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Clearing pass over the channel memory after reset.
  logic                    clr_busy_r;
  logic [AW-1:0]           clr_idx_r;

  // Stage 1: state read in flight.
  logic                    s1_v_r;
  logic [CH_W-1:0]         s1_ch_r;
  logic [TIME_W-1:0]       s1_time_r;
  logic signed [VAL_W-1:0] s1_value_r;
  logic [1:0]              s1_unit_r;

  // Stage 2: decide and write back.
  logic                    s2_v_r;
  logic [CH_W-1:0]         s2_ch_r;
  logic [TIME_W-1:0]       s2_time_r;
  logic signed [VAL_W-1:0] s2_value_r;
  logic [1:0]              s2_unit_r;
  logic [VAL_W:0]          s2_d_r;
  logic [TIME_W:0]         s2_dt_r;
  chan_word_t              s2_word_r;

  // Last write, for a read that coincided with it.
  logic                    fwd_v_r;
  logic [CH_W-1:0]         fwd_ch_r;
  chan_word_t              fwd_word_r;

  logic                    in_range;
  logic [AW-1:0]           ram_raddr;
  chan_word_t              ram_rdata;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  chan_word_t              ram_wdata;
  chan_word_t              s1_word;
  logic [VAL_W:0]          s1_d;
  logic [TIME_W:0]         s1_dt;
  logic                    s1_move;
  logic                    s2_ready;
  logic [STEP_W-1:0]       step_sel;
  logic [VAL_W+1:0]        neg_sum;
  logic                    mag_ge;
  logic                    exceed;
  logic                    dt_ok;
  logic                    first;
  logic                    emit_held;
  logic [1:0]              need;
  logic                    commit;
  chan_word_t              new_word;
  point_t                  cur_pt;
  point_t                  held_pt;

  assign in_range = (32'(in_ch) < CHANNELS);

  // Hand-off between stages; a same-channel pair waits for the write back.
  assign s2_ready  = !s2_v_r || commit;
  assign s1_move   = s1_v_r && s2_ready && !(s2_v_r && (s2_ch_r == s1_ch_r));
  assign in_ready  = !clr_busy_r && (!s1_v_r || s1_move);
  assign ram_raddr = in_ready ? in_ch[AW-1:0] : s1_ch_r[AW-1:0];

  // The clearing pass owns the write port until every entry is zero.
  assign ram_we    = commit || clr_busy_r;
  assign ram_waddr = clr_busy_r ? clr_idx_r : s2_ch_r[AW-1:0];
  assign ram_wdata = clr_busy_r ? '0 : new_word;

  dwc_ram #(
    .WIDTH ($bits(chan_word_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One entry cleared per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Stage 1: pick the current state word and form both differences.
  always_comb begin
    s1_word = (fwd_v_r && (fwd_ch_r == s1_ch_r)) ? fwd_word_r : ram_rdata;
    s1_d    = {s1_value_r[VAL_W-1], s1_value_r}
            - {s1_word.lk_value[VAL_W-1], s1_word.lk_value};
    s1_dt   = {1'b0, s1_word.held_time} - {1'b0, s1_word.lk_time};
  end

  // Stage 2: deadband test for the sample's unit.
  always_comb begin
    unique case (s2_unit_r)
      UNIT_CURRENT: step_sel = cfg.current_step;
      UNIT_VOLTAGE: step_sel = cfg.volt_step;
      default:      step_sel = '0;
    endcase
    // A negative difference passes when adding the step leaves it at or below zero.
    neg_sum = {s2_d_r[VAL_W], s2_d_r} + {3'b000, step_sel};
    if (s2_d_r[VAL_W]) begin
      mag_ge = neg_sum[VAL_W+1] || (neg_sum == '0);
    end else begin
      mag_ge = (s2_d_r[VAL_W-1:0] >= {1'b0, step_sel});
    end
    unique case (s2_unit_r)
      UNIT_CURRENT: exceed = mag_ge;
      UNIT_VOLTAGE: exceed = mag_ge;
      UNIT_NONE:    exceed = 1'b0;
      default:      exceed = 1'b1;
    endcase
    dt_ok     = !s2_dt_r[TIME_W] && (s2_dt_r[TIME_W-1:0] >= cfg.time_step);
    first     = !s2_word_r.has_kept;
    emit_held = s2_word_r.held_valid && dt_ok;
  end

  // Stage 2: result count, new state word and result points.
  always_comb begin
    priority if (first) begin
      need = 2'd1;
    end else if (!exceed) begin
      need = 2'd0;
    end else if (emit_held) begin
      need = 2'd2;
    end else begin
      need = 2'd1;
    end
    commit = s2_v_r && ({1'b0, need} <= fifo_free);

    new_word          = s2_word_r;
    new_word.has_kept = 1'b1;
    // The first sample leaves the held flag as it is.
    new_word.held_valid = first ? s2_word_r.held_valid : !exceed;
    if (first || exceed) begin
      new_word.lk_time  = s2_time_r;
      new_word.lk_value = s2_value_r;
    end else begin
      new_word.held_time  = s2_time_r;
      new_word.held_value = s2_value_r;
    end

    cur_pt.channel  = s2_ch_r;
    cur_pt.time_fs  = s2_time_r;
    cur_pt.value    = s2_value_r;
    cur_pt.last     = 1'b1;
    held_pt.channel = s2_ch_r;
    held_pt.time_fs = s2_word_r.held_time;
    held_pt.value   = s2_word_r.held_value;
    held_pt.last    = 1'b0;

    push.push0 = commit && (need != 2'd0);
    push.push1 = commit && (need == 2'd2);
    push.pt0   = (need == 2'd2) ? held_pt : cur_pt;
    push.pt1   = cur_pt;
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid && in_range;
      end
      if (s2_ready) begin
        s2_v_r <= s1_move;
      end
      fwd_v_r <= commit;
    end
  end

  // Stage payloads and the forwarding copy.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_ch_r    <= in_ch;
      s1_time_r  <= in_time;
      s1_value_r <= in_value;
      s1_unit_r  <= in_unit;
    end
    if (s1_move) begin
      s2_ch_r    <= s1_ch_r;
      s2_time_r  <= s1_time_r;
      s2_value_r <= s1_value_r;
      s2_unit_r  <= s1_unit_r;
      s2_d_r     <= s1_d;
      s2_dt_r    <= s1_dt;
      s2_word_r  <= s1_word;
    end
    if (commit) begin
      fwd_ch_r   <= s2_ch_r;
      fwd_word_r <= new_word;
    end
  end

  `ASSERT_CLK(a_s2_holds, (s2_v_r && !commit) |=> (s2_v_r && $stable(s2_ch_r)))
  `ASSERT_CLK(a_s1_into_free_s2, (s1_move && s2_v_r) |-> commit)
  `ASSERT_CLK(a_held_needs_kept, (s2_v_r && s2_word_r.held_valid) |-> s2_word_r.has_kept)
  `ASSERT_NEVER(a_no_take_in_clear, clr_busy_r && in_ready)

endmodule

FILE: sv/deadband_waveform_compressor_core.sv
// A sample accepted is registered in stage 1, then stage 2, then the result queue before its first point shows.
// Throughput: one sample a cycle while the result queue has room; a sample that releases a held point needs two
// output beats, and a sample on the channel of the one just ahead waits
// for that state read-modify-write in the channel memory to finish.
// Reset: a clearing pass over every channel entry zeroes the channel memory with in_ready low;
// the step registers return to 10 mV, 10 uA, 1 ps.
module deadband_waveform_compressor_core #(
  parameter int CHANNELS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dwc_pkg::CH_W-1:0]              in_channel,
  input  logic [dwc_pkg::TIME_W-1:0]            in_sample_time,
  input  logic signed [dwc_pkg::VAL_W-1:0]      in_sample_value,
  input  logic [1:0]                            in_unit_kind,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dwc_pkg::CH_W-1:0]              out_kept_channel,
  output logic [dwc_pkg::TIME_W-1:0]            out_kept_time,
  output logic signed [dwc_pkg::VAL_W-1:0]      out_kept_value,
  output logic                                  out_last_of_run,
  input  logic                                  cfg_we,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dwc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import dwc_pkg::*;

  cfg_t             cfg_r;
  push_t            push;
  logic [CNT_W-1:0] fifo_free;
  point_t           out_pt;

  // Step registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volt_step    <= VOLT_STEP_RST;
      cfg_r.current_step <= CURRENT_STEP_RST;
      cfg_r.time_step    <= TIME_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLT_STEP:    cfg_r.volt_step    <= cfg_data[STEP_W-1:0];
        CFG_CURRENT_STEP: cfg_r.current_step <= cfg_data[STEP_W-1:0];
        CFG_TIME_STEP:    cfg_r.time_step    <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dwc_chan_pipe #(
    .CHANNELS (CHANNELS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_channel),
    .in_time   (in_sample_time),
    .in_value  (in_sample_value),
    .in_unit   (in_unit_kind),
    .cfg       (cfg_r),
    .fifo_free (fifo_free),
    .push      (push)
  );

  dwc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .free      (fifo_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pt    (out_pt)
  );

  assign out_kept_channel = out_pt.channel;
  assign out_kept_time    = out_pt.time_fs;
  assign out_kept_value   = out_pt.value;
  assign out_last_of_run  = out_pt.last;

endmodule
